>>> rtl/ocdf_pkg.sv
// Package for the OFDM derotation, prefix strip and FFT block.
// Holds sizes, fixed-point helpers, CORDIC table and controller state type.
// Used by ocdf_cordic, ocdf_datapath, ocdf_ctrl and the top level; depends on nothing.
package ocdf_pkg;

	localparam int POINTS_DEF    = 64;
	localparam int SYMBOLS_DEF   = 1;
	localparam int CP_LEN_DEF    = 16;
	localparam int CORDIC_STEPS  = 15;
	localparam int CORDIC_IW     = 4;
	localparam logic signed [33:0] CORDIC_X0 = 34'sd652032874;

	// arctangent of 2^-i in pi*2^-15 units
	function automatic logic signed [16:0] atan_units(input logic [CORDIC_IW-1:0] i);
		logic signed [16:0] r;
		begin
			unique case (i)
				4'd0: r = 17'sd8192;
				4'd1: r = 17'sd4836;
				4'd2: r = 17'sd2555;
				4'd3: r = 17'sd1297;
				4'd4: r = 17'sd651;
				4'd5: r = 17'sd326;
				4'd6: r = 17'sd163;
				4'd7: r = 17'sd81;
				4'd8: r = 17'sd41;
				4'd9: r = 17'sd20;
				4'd10: r = 17'sd10;
				4'd11: r = 17'sd5;
				4'd12: r = 17'sd3;
				4'd13: r = 17'sd1;
				4'd14: r = 17'sd1;
				default: r = 17'sd0;
			endcase
			return r;
		end
	endfunction

	typedef enum logic [3:0] {
		ST_LOAD,
		ST_RD,
		ST_COS,
		ST_ROT,
		ST_BF_RA,
		ST_BF_RB,
		ST_BF_TW,
		ST_BF_WA,
		ST_BF_WB,
		ST_OUT
	} ctrl_state_t;

	// controller to datapath
	typedef struct packed {
		logic        store_wr;   // write accepted sample
		logic        step_ld;    // take phase step, clear accumulator
		logic        fs_rd;      // read frame store
		logic        cordic_go;  // start sine/cosine
		logic        cordic_tw;  // cordic angle from twiddle, else from accumulator
		logic        rot_mul;    // derotation products
		logic        rot_wr;     // write derotated sample to work buffer
		logic        phase_adv;  // advance accumulator
		logic        bf_rd_a;    // read butterfly top
		logic        bf_rd_b;    // read butterfly bottom
		logic        bf_mul;     // twiddle products
		logic        bf_wr_a;    // write top result
		logic        bf_wr_b;    // write bottom result
		logic        out_rd;     // read bin for output
	} ctrl_cmd_t;

	typedef struct packed {
		logic cordic_busy;
	} dp_stat_t;

	function automatic logic signed [23:0] sat24(input logic signed [25:0] v);
		if (v > 26'sd8388607) return 24'sh7FFFFF;
		if (v < -26'sd8388608) return 24'sh800000;
		return v[23:0];
	endfunction

	function automatic logic signed [15:0] sat16(input logic signed [33:0] v);
		if (v > 34'sd32767) return 16'sh7FFF;
		if (v < -34'sd32768) return 16'sh8000;
		return v[15:0];
	endfunction

endpackage

>>> rtl/ocdf_if.sv
// Valid/ready stream interface with a generic payload.
// Depends on nothing; used by the top level.
interface ocdf_if #(parameter int W = 32);
	logic         valid;
	logic         ready;
	logic [W-1:0] data;
	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/ocdf_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
// Depends on nothing.
module ocdf_ram #(
	parameter int W = 32,
	parameter int D = 64
) (
	input  logic                 clk,
	input  logic                 we,
	input  logic [$clog2(D)-1:0] waddr,
	input  logic [W-1:0]         wdata,
	input  logic                 re,
	input  logic [$clog2(D)-1:0] raddr,
	output logic [W-1:0]         rdata
);
	logic [W-1:0] mem [D];

	// write, and register the read word
	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		if (re) rdata <= mem[raddr];
	end
endmodule

>>> rtl/ocdf_cordic.sv
// Iterative rotation-mode CORDIC: 16-bit phase to Q1.15 cosine and sine.
// Depends on ocdf_pkg. One iteration per cycle; busy from go until the result is registered.
module ocdf_cordic (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               go,
	input  logic [15:0]        phase,
	output logic               busy,
	output logic signed [15:0] cos_o,
	output logic signed [15:0] sin_o
);
	logic signed [33:0] x_q, y_q;
	logic signed [16:0] z_q;
	logic [ocdf_pkg::CORDIC_IW-1:0] it_q;
	logic neg_q, run_q, fin_q;
	logic [15:0] p_f;
	logic signed [33:0] dx, dy, xr, yr;
	logic signed [16:0] at;

	always_comb begin
		p_f = phase;
		if (phase >= 16'd16384 && phase < 16'd49152) p_f = phase - 16'd32768;
		dx = y_q >>> it_q;
		dy = x_q >>> it_q;
		at = ocdf_pkg::atan_units(it_q);
		xr = (x_q + 34'sd16384) >>> 15;
		yr = (y_q + 34'sd16384) >>> 15;
		if (neg_q) begin
			xr = -xr;
			yr = -yr;
		end
	end

	assign busy = run_q | fin_q;

	// iterate, then round and saturate
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			fin_q <= 1'b0;
			it_q  <= '0;
		end else begin
			fin_q <= 1'b0;
			if (go) begin
				run_q <= 1'b1;
				it_q  <= '0;
				x_q   <= ocdf_pkg::CORDIC_X0;
				y_q   <= '0;
				z_q   <= {p_f[15], p_f};
				neg_q <= (phase >= 16'd16384 && phase < 16'd49152);
			end else if (run_q) begin
				if (z_q >= 0) begin
					x_q <= x_q - dx;
					y_q <= y_q + dy;
					z_q <= z_q - at;
				end else begin
					x_q <= x_q + dx;
					y_q <= y_q - dy;
					z_q <= z_q + at;
				end
				if (it_q == ocdf_pkg::CORDIC_IW'(ocdf_pkg::CORDIC_STEPS - 1)) begin
					run_q <= 1'b0;
					fin_q <= 1'b1;
				end
				it_q <= it_q + ocdf_pkg::CORDIC_IW'(1);
			end else if (fin_q) begin
				cos_o <= ocdf_pkg::sat16(xr);
				sin_o <= ocdf_pkg::sat16(yr);
			end
		end
	end
endmodule

>>> rtl/ocdf_datapath.sv
// Datapath: frame store, work buffer, phase accumulator, CORDIC, multipliers.
// Depends on ocdf_pkg, ocdf_ram and ocdf_cordic.
module ocdf_datapath #(
	parameter int POINTS    = ocdf_pkg::POINTS_DEF,
	parameter int FRAME_LEN = 80,
	localparam int FAW = (FRAME_LEN > 1) ? $clog2(FRAME_LEN) : 1,
	localparam int LW  = $clog2(POINTS)
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  ocdf_pkg::ctrl_cmd_t   cmd,
	output ocdf_pkg::dp_stat_t    stat,
	input  logic [31:0]           in_word,
	input  logic [FAW-1:0]        fs_waddr,
	input  logic [FAW-1:0]        fs_raddr,
	input  logic [LW-1:0]         wb_dst,
	input  logic [LW-1:0]         addr_a,
	input  logic [LW-1:0]         addr_b,
	input  logic [15:0]           tw_phase,
	output logic [47:0]           bin_word
);
	logic [31:0] fs_rdata;
	logic [15:0] step_q, acc_q;
	logic signed [15:0] c, s;
	logic cbusy;
	logic signed [39:0] p0_s1, p1_s1, p2_s1, p3_s1;
	logic signed [23:0] ar_q, ai_q, br_q, bi_q;
	logic wb_we, wb_re;
	logic [LW-1:0] wb_wa, wb_ra;
	logic [47:0] wb_wd, wb_rd;
	logic rd_b_q;
	logic signed [41:0] tr, ti;
	logic signed [25:0] sumr, sumi, difr, difi;
	logic signed [15:0] sa, sb;
	logic [15:0] dr, di;

	ocdf_ram #(.W(32), .D(FRAME_LEN)) u_fs (
		.clk(clk), .we(cmd.store_wr), .waddr(fs_waddr), .wdata(in_word),
		.re(cmd.fs_rd), .raddr(fs_raddr), .rdata(fs_rdata));

	ocdf_cordic u_cordic (
		.clk(clk), .arst_n(arst_n), .go(cmd.cordic_go),
		.phase(cmd.cordic_tw ? tw_phase : acc_q), .busy(cbusy), .cos_o(c), .sin_o(s));

	assign stat.cordic_busy = cbusy;

	// phase accumulator
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q  <= '0;
			step_q <= '0;
		end else if (cmd.step_ld) begin
			acc_q  <= '0;
			step_q <= in_word[31:16];
		end else if (cmd.phase_adv) begin
			acc_q <= acc_q + step_q;
		end
	end

	// products: derotation uses frame word, butterfly uses bottom operand; hold otherwise
	assign sa = fs_rdata[31:16];
	assign sb = fs_rdata[15:0];
	always_ff @(posedge clk) begin
		if (cmd.bf_mul) begin
			p0_s1 <= 40'(br_q) * 40'(c);
			p1_s1 <= 40'(bi_q) * 40'(s);
			p2_s1 <= 40'(br_q) * 40'(s);
			p3_s1 <= 40'(bi_q) * 40'(c);
		end else if (cmd.rot_mul) begin
			p0_s1 <= 40'(sa) * 40'(c);
			p1_s1 <= 40'(sb) * 40'(s);
			p2_s1 <= 40'(sa) * 40'(s);
			p3_s1 <= 40'(sb) * 40'(c);
		end
	end

	always_comb begin
		tr = ((42'(p0_s1) - 42'(p1_s1)) + 42'sd16384) >>> 15;
		ti = ((42'(p2_s1) + 42'(p3_s1)) + 42'sd16384) >>> 15;
		dr = ocdf_pkg::sat16(34'(tr));
		di = ocdf_pkg::sat16(34'(ti));
		sumr = 26'(ar_q) + 26'(tr);
		sumi = 26'(ai_q) + 26'(ti);
		difr = 26'(ar_q) - 26'(tr);
		difi = 26'(ai_q) - 26'(ti);
	end

	// capture butterfly operands from the work buffer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) rd_b_q <= 1'b0;
		else rd_b_q <= cmd.bf_rd_b;
	end
	always_ff @(posedge clk) begin
		if (cmd.bf_rd_b) begin
			ar_q <= wb_rd[47:24];
			ai_q <= wb_rd[23:0];
		end
		if (rd_b_q) begin
			br_q <= wb_rd[47:24];
			bi_q <= wb_rd[23:0];
		end
	end

	// work buffer port selection
	always_comb begin
		wb_re = cmd.bf_rd_a | cmd.bf_rd_b | cmd.out_rd;
		wb_ra = cmd.bf_rd_b ? addr_b : addr_a;
		wb_we = cmd.rot_wr | cmd.bf_wr_a | cmd.bf_wr_b;
		wb_wa = cmd.rot_wr ? wb_dst : (cmd.bf_wr_b ? addr_b : addr_a);
		if (cmd.rot_wr)
			wb_wd = {{8{dr[15]}}, dr, {8{di[15]}}, di};
		else if (cmd.bf_wr_b)
			wb_wd = {ocdf_pkg::sat24(difr), ocdf_pkg::sat24(difi)};
		else
			wb_wd = {ocdf_pkg::sat24(sumr), ocdf_pkg::sat24(sumi)};
	end

	ocdf_ram #(.W(48), .D(POINTS)) u_wb (
		.clk(clk), .we(wb_we), .waddr(wb_wa), .wdata(wb_wd),
		.re(wb_re), .raddr(wb_ra), .rdata(wb_rd));

	assign bin_word = wb_rd;
endmodule

>>> rtl/ocdf_ctrl.sv
// Controller: load, derotate/strip, FFT stage sequencing and bin output.
// Depends on ocdf_pkg.
module ocdf_ctrl #(
	parameter int POINTS    = ocdf_pkg::POINTS_DEF,
	parameter int SYMBOLS   = ocdf_pkg::SYMBOLS_DEF,
	parameter int CP_LEN    = ocdf_pkg::CP_LEN_DEF,
	localparam int SYM_LEN   = POINTS + CP_LEN,
	localparam int FRAME_LEN = SYMBOLS * SYM_LEN,
	localparam int FAW = (FRAME_LEN > 1) ? $clog2(FRAME_LEN) : 1,
	localparam int LW  = $clog2(POINTS),
	localparam int SW  = $clog2(SYM_LEN + 1),
	localparam int YW  = $clog2(SYMBOLS + 1),
	localparam int GW  = $clog2(LW + 1)
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	output logic                out_valid,
	input  logic                out_ready,
	output logic                frame_last,
	output ocdf_pkg::ctrl_cmd_t cmd,
	input  ocdf_pkg::dp_stat_t  stat,
	output logic [FAW-1:0]      fs_waddr,
	output logic [FAW-1:0]      fs_raddr,
	output logic [LW-1:0]       wb_dst,
	output logic [LW-1:0]       addr_a,
	output logic [LW-1:0]       addr_b,
	output logic [15:0]         tw_phase
);
	ocdf_pkg::ctrl_state_t st_q, st_d;
	logic [FAW:0] cnt_q;          // load count / frame read pointer
	logic [SW-1:0] j_q;           // place within symbol
	logic [YW-1:0] sym_q;
	logic [GW-1:0] stg_q;         // butterfly span is 2^stg_q
	logic [LW-1:0] k_q, m_q;      // twiddle index, group base
	logic [LW:0]   o_q;           // output bin index
	logic          ov_q;          // output word held
	logic [LW-1:0] jr;
	logic [LW-1:0] jd;
	logic          last_k, last_m, last_stg, last_o, last_sym, in_cp, last_j, frame_full;

	// bit-reverse of the useful sample index
	always_comb begin
		jd = LW'(j_q - SW'(CP_LEN));
		for (int b = 0; b < LW; b++) jr[b] = jd[LW-1-b];
	end

	assign fs_waddr = cnt_q[FAW-1:0];
	assign fs_raddr = cnt_q[FAW-1:0];
	assign wb_dst   = jr;
	assign in_cp    = j_q < SW'(CP_LEN);
	assign addr_a   = k_q + m_q;
	assign addr_b   = (k_q + m_q) | (LW'(1) << stg_q);
	// -k*65536/len, len = 2^(stg+1)
	assign tw_phase = 16'(0) - (16'(k_q) << (5'd15 - 5'(stg_q)));
	assign last_k   = k_q == LW'((1 << stg_q) - 1);
	assign last_m   = (32'(m_q) + (32'd2 << stg_q)) >= 32'(POINTS);
	assign last_stg = stg_q == GW'(LW - 1);
	assign last_o   = o_q == (LW+1)'(POINTS - 1);
	assign last_sym = sym_q == YW'(SYMBOLS - 1);
	assign last_j   = j_q == SW'(SYM_LEN - 1);
	assign frame_full = cnt_q == (FAW+1)'(FRAME_LEN);
	assign out_valid = ov_q;
	assign frame_last = ov_q & last_o & last_sym;

	// next state and commands
	always_comb begin
		st_d = st_q;
		cmd = '0;
		in_ready = 1'b0;
		unique case (st_q)
			ocdf_pkg::ST_LOAD: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (frame_full) begin
						cmd.step_ld = 1'b1;
						st_d = ocdf_pkg::ST_RD;
					end else begin
						cmd.store_wr = 1'b1;
					end
				end
			end
			ocdf_pkg::ST_RD: begin
				cmd.fs_rd = 1'b1;
				cmd.cordic_go = 1'b1;
				st_d = ocdf_pkg::ST_COS;
			end
			ocdf_pkg::ST_COS: begin
				if (!stat.cordic_busy) begin
					cmd.rot_mul = 1'b1;
					st_d = ocdf_pkg::ST_ROT;
				end
			end
			ocdf_pkg::ST_ROT: begin
				cmd.phase_adv = 1'b1;
				cmd.rot_wr = !in_cp;
				st_d = last_j ? ocdf_pkg::ST_BF_RA : ocdf_pkg::ST_RD;
			end
			ocdf_pkg::ST_BF_RA: begin
				cmd.bf_rd_a = 1'b1;
				st_d = ocdf_pkg::ST_BF_RB;
			end
			ocdf_pkg::ST_BF_RB: begin
				// read bottom and start the twiddle
				cmd.bf_rd_b = 1'b1;
				cmd.cordic_go = 1'b1;
				cmd.cordic_tw = 1'b1;
				st_d = ocdf_pkg::ST_BF_TW;
			end
			ocdf_pkg::ST_BF_TW: begin
				if (!stat.cordic_busy) begin
					cmd.bf_mul = 1'b1;
					st_d = ocdf_pkg::ST_BF_WA;
				end
			end
			ocdf_pkg::ST_BF_WA: begin
				cmd.bf_wr_a = 1'b1;
				st_d = ocdf_pkg::ST_BF_WB;
			end
			ocdf_pkg::ST_BF_WB: begin
				cmd.bf_wr_b = 1'b1;
				st_d = (last_m && last_k && last_stg) ? ocdf_pkg::ST_OUT
					: ocdf_pkg::ST_BF_RA;
			end
			ocdf_pkg::ST_OUT: begin
				if (!ov_q || out_ready) begin
					if (ov_q && last_o)
						st_d = last_sym ? ocdf_pkg::ST_LOAD : ocdf_pkg::ST_RD;
					else
						cmd.out_rd = 1'b1;
				end
			end
			default: st_d = ocdf_pkg::ST_LOAD;
		endcase
	end

	// state register and loop counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= ocdf_pkg::ST_LOAD;
			cnt_q  <= '0;
			j_q    <= '0;
			sym_q  <= '0;
			stg_q  <= '0;
			k_q    <= '0;
			m_q    <= '0;
			o_q    <= '0;
			ov_q   <= 1'b0;
		end else begin
			st_q <= st_d;
			unique case (st_q)
				ocdf_pkg::ST_LOAD: begin
					if (in_valid) begin
						if (frame_full) cnt_q <= '0;
						else cnt_q <= cnt_q + (FAW+1)'(1);
					end
					j_q <= '0;
					sym_q <= '0;
				end
				ocdf_pkg::ST_ROT: begin
					cnt_q <= cnt_q + (FAW+1)'(1);
					if (last_j) begin
						j_q <= '0;
						stg_q <= '0;
						k_q <= '0;
						m_q <= '0;
					end else begin
						j_q <= j_q + SW'(1);
					end
				end
				ocdf_pkg::ST_BF_WB: begin
					if (!last_m) begin
						m_q <= m_q + LW'(2 << stg_q);
					end else if (!last_k) begin
						m_q <= '0;
						k_q <= k_q + LW'(1);
					end else if (!last_stg) begin
						m_q <= '0;
						k_q <= '0;
						stg_q <= stg_q + GW'(1);
					end else begin
						k_q <= '0;
						m_q <= '0;
						o_q <= '0;
						ov_q <= 1'b0;
					end
				end
				// output read address walks the bins in order
				ocdf_pkg::ST_OUT: begin
					if (!ov_q || out_ready) begin
						if (ov_q && last_o) begin
							ov_q <= 1'b0;
							o_q <= '0;
							if (last_sym) cnt_q <= '0;
							else sym_q <= sym_q + YW'(1);
						end else begin
							ov_q <= 1'b1;
							if (ov_q) o_q <= o_q + (LW+1)'(1);
							k_q <= k_q + LW'(1);
						end
					end
				end
				default: ;
			endcase
		end
	end
endmodule

>>> rtl/ofdm_cfo_derotate_cp_strip_fft.sv
// OFDM front end: frequency-offset derotation, cyclic prefix removal, FFT.
// Depends on ocdf_pkg, ocdf_if, ocdf_ram, ocdf_cordic, ocdf_ctrl, ocdf_datapath.
//
// Send SYMBOLS_PER_FRAME*(POINTS+CP_LEN) sample words, then one word whose
// sample_re is the phase step per sample (pi*2^-15 rad units). Loading takes
// one cycle a word. After the step word the block rotates each stored sample
// with a 15-step iterative CORDIC, then runs the radix-2 FFT on one shared
// butterfly that also computes each twiddle with the CORDIC, with
// (POINTS/2)*log2(POINTS) butterflies per symbol, then drains POINTS bins one
// a cycle while the output is ready. Input is held off until the last bin of
// the frame, marked by frame_last, has been taken.
module ofdm_cfo_derotate_cp_strip_fft #(
	parameter int POINTS            = ocdf_pkg::POINTS_DEF,
	parameter int SYMBOLS_PER_FRAME = ocdf_pkg::SYMBOLS_DEF,
	parameter int CP_LEN            = ocdf_pkg::CP_LEN_DEF
) (
	input logic  clk,
	input logic  arst_n,
	ocdf_if.sink   in_ch,
	ocdf_if.source out_ch
);
	localparam int FRAME_LEN = SYMBOLS_PER_FRAME * (POINTS + CP_LEN);
	localparam int FAW = (FRAME_LEN > 1) ? $clog2(FRAME_LEN) : 1;
	localparam int LW  = $clog2(POINTS);

	ocdf_pkg::ctrl_cmd_t cmd;
	ocdf_pkg::dp_stat_t  stat;
	logic [FAW-1:0] fs_waddr, fs_raddr;
	logic [LW-1:0] wb_dst, addr_a, addr_b;
	logic [15:0] tw_phase;
	logic [47:0] bin_word;
	logic flast;

	ocdf_ctrl #(.POINTS(POINTS), .SYMBOLS(SYMBOLS_PER_FRAME), .CP_LEN(CP_LEN)) u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
		.out_valid(out_ch.valid), .out_ready(out_ch.ready), .frame_last(flast),
		.cmd(cmd), .stat(stat), .fs_waddr(fs_waddr), .fs_raddr(fs_raddr),
		.wb_dst(wb_dst), .addr_a(addr_a), .addr_b(addr_b), .tw_phase(tw_phase));

	ocdf_datapath #(.POINTS(POINTS), .FRAME_LEN(FRAME_LEN)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .stat(stat),
		.in_word(in_ch.data), .fs_waddr(fs_waddr), .fs_raddr(fs_raddr),
		.wb_dst(wb_dst), .addr_a(addr_a), .addr_b(addr_b), .tw_phase(tw_phase),
		.bin_word(bin_word));

	assign out_ch.data = {bin_word, flast};

`ifndef SYNTHESIS
	// no input taken while bins are pending
	a_no_in_during_out: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid |-> !in_ch.ready) else $error("input taken during output");
	// frame end only with a valid word
	a_last_valid: assert property (@(posedge clk) disable iff (!arst_n)
		flast |-> out_ch.valid) else $error("frame_last without valid");
`endif
endmodule

>>> tb/sv/tb_ofdm_cfo_derotate_cp_strip_fft.sv
// Testbench for ofdm_cfo_derotate_cp_strip_fft: sends sample frames and step words,
// predicts every FFT bin in fixed point and checks the output stream word by word.
// Depends on ocdf_pkg, ocdf_if and the block itself.
module tb_ofdm_cfo_derotate_cp_strip_fft;

	localparam int NFFT      = ocdf_pkg::POINTS_DEF;
	localparam int NCP       = ocdf_pkg::CP_LEN_DEF;
	localparam int NSYM      = ocdf_pkg::SYMBOLS_DEF;
	localparam int SYM_WORDS = NFFT + NCP;
	localparam int FRAME_WORDS = NSYM * SYM_WORDS;
	localparam int WDOG_LIMIT = 40000;

	typedef struct {
		logic [31:0] data;
		bit          hold;   // wait for all bins before sending
		bit          quiet;  // no idling on either side
	} tx_word_t;

	typedef struct {
		logic signed [23:0] re;
		logic signed [23:0] im;
		logic               last;
	} bin_t;

	logic clk;
	logic arst_n;

	ocdf_if #(.W(32)) in_ch  ();
	ocdf_if #(.W(49)) out_ch ();

	ofdm_cfo_derotate_cp_strip_fft u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch),
		.out_ch(out_ch)
	);

	tx_word_t tx_queue[$];
	bin_t     bins_due[$];
	int       fail_count;
	bit       quiet_now;

	// captured raw samples of the frame being loaded
	logic [31:0] frame_buf[FRAME_WORDS];
	int          load_count;
	longint      acc_re[NFFT];
	longint      acc_im[NFFT];

	initial clk = 1'b0;
	always #6 clk = ~clk;

	function automatic longint clip(longint v, int bits);
		longint hi;
		longint lo;
		hi = (longint'(1) <<< (bits - 1)) - 1;
		lo = -hi - 1;
		return v > hi ? hi : (v < lo ? lo : v);
	endfunction

	function automatic longint rnd15(longint v);
		return (v + 16384) >>> 15;
	endfunction

	function automatic longint atan_tab(int i);
		longint t[15] = '{8192, 4836, 2555, 1297, 651, 326, 163, 81, 41, 20, 10, 5, 3, 1, 1};
		return t[i];
	endfunction

	// CORDIC sine/cosine of a 16-bit phase
	task automatic sin_cos(input logic [15:0] ph, output longint c, output longint s);
		bit     neg;
		longint x;
		longint y;
		longint z;
		longint dx;
		longint dy;
		logic [15:0] p;
		p = ph;
		neg = 0;
		x = 652032874;
		y = 0;
		if (p >= 16'd16384 && p < 16'd49152) begin
			p = p - 16'd32768;
			neg = 1;
		end
		z = longint'($signed(p));
		for (int i = 0; i < 15; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (z >= 0) begin
				x -= dx; y += dy; z -= atan_tab(i);
			end else begin
				x += dx; y -= dy; z += atan_tab(i);
			end
		end
		x = rnd15(x);
		y = rnd15(y);
		if (neg) begin
			x = -x; y = -y;
		end
		c = clip(x, 16);
		s = clip(y, 16);
	endtask

	function automatic int rev_bits(int v);
		int r;
		r = 0;
		for (int n = 1; n < NFFT; n <<= 1) begin
			r = (r << 1) | (v & 1);
			v >>= 1;
		end
		return r;
	endfunction

	// derotate the stored frame, strip prefixes, transform, queue the bins
	task automatic predict_bins(input logic [15:0] step);
		logic [15:0] ph;
		longint a, b, c, s, wr, wi, tr, ti, ar, ai;
		int     idx, bb, half;
		bin_t   e;
		ph = '0;
		for (int sym = 0; sym < NSYM; sym++) begin
			for (int j = 0; j < SYM_WORDS; j++) begin
				idx = sym * SYM_WORDS + j;
				a = longint'($signed(frame_buf[idx][31:16]));
				b = longint'($signed(frame_buf[idx][15:0]));
				sin_cos(ph, c, s);
				ph = ph + step;
				if (j >= NCP) begin
					acc_re[rev_bits(j - NCP)] = clip(rnd15(a * c - b * s), 16);
					acc_im[rev_bits(j - NCP)] = clip(rnd15(a * s + b * c), 16);
				end
			end
			for (int len = 2; len <= NFFT; len <<= 1) begin
				half = len >> 1;
				for (int k = 0; k < half; k++) begin
					sin_cos(16'(0 - k * (65536 / len)), wr, wi);
					for (int m = k; m < NFFT; m += len) begin
						bb = m + half;
						tr = rnd15(acc_re[bb] * wr - acc_im[bb] * wi);
						ti = rnd15(acc_re[bb] * wi + acc_im[bb] * wr);
						ar = acc_re[m];
						ai = acc_im[m];
						acc_re[m]  = clip(ar + tr, 24);
						acc_im[m]  = clip(ai + ti, 24);
						acc_re[bb] = clip(ar - tr, 24);
						acc_im[bb] = clip(ai - ti, 24);
					end
				end
			end
			for (int j = 0; j < NFFT; j++) begin
				e.re = 24'(acc_re[j]);
				e.im = 24'(acc_im[j]);
				e.last = (sym == NSYM - 1 && j == NFFT - 1);
				bins_due.push_back(e);
			end
		end
	endtask

	task automatic report(input string what, input logic [47:0] got, input logic [47:0] want);
		$display("mismatch %s: got %h want %h at %0t", what, got, want, $time);
		fail_count++;
	endtask

	function automatic bit idle_roll();
		return !quiet_now && ($urandom_range(99) < 12);
	endfunction

	// driver: present words from the queue, store accepted samples, predict on each accepted step word
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_ch.valid <= 1'b0;
			in_ch.data  <= '0;
			load_count  <= 0;
		end else begin
			if (in_ch.valid && in_ch.ready) begin
				if (load_count < FRAME_WORDS) begin
					frame_buf[load_count] = in_ch.data;
					load_count <= load_count + 1;
				end else begin
					predict_bins(in_ch.data[31:16]);
					load_count <= 0;
				end
			end
			if (!in_ch.valid || in_ch.ready) begin
				if (tx_queue.size() > 0 && !(tx_queue[0].hold && bins_due.size() > 0)
						&& !idle_roll()) begin
					in_ch.valid <= 1'b1;
					in_ch.data  <= tx_queue[0].data;
					quiet_now   <= tx_queue[0].quiet;
					void'(tx_queue.pop_front());
				end else begin
					in_ch.valid <= 1'b0;
				end
			end
		end
	end

	// monitor: stall at random, compare each accepted bin with the oldest due
	always @(posedge clk or negedge arst_n) begin
		bin_t e;
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
		end else begin
			out_ch.ready <= !idle_roll();
			if (out_ch.valid && out_ch.ready) begin
				if (bins_due.size() == 0) begin
					report("unexpected bin", 48'(out_ch.data), '0);
				end else begin
					e = bins_due.pop_front();
					if (out_ch.data[48:25] !== e.re)
						report("bin_re", 48'(out_ch.data[48:25]), 48'(e.re));
					if (out_ch.data[24:1] !== e.im)
						report("bin_im", 48'(out_ch.data[24:1]), 48'(e.im));
					if (out_ch.data[0] !== e.last)
						report("frame_last", 48'(out_ch.data[0]), 48'(e.last));
				end
			end
		end
	end

	// watchdog: end the run when nothing moves for too long
	int stall_cycles;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stall_cycles <= 0;
		end else if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= WDOG_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	task automatic add_word(input logic [15:0] re, input logic [15:0] im,
			input bit hold, input bit quiet);
		tx_word_t w;
		w.data = {re, im};
		w.hold = hold;
		w.quiet = quiet;
		tx_queue.push_back(w);
	endtask

	// one frame: kind picks the sample pattern, then the step word
	task automatic add_frame(input int kind, input logic [15:0] step,
			input bit hold, input bit quiet);
		logic [15:0] re, im;
		for (int i = 0; i < FRAME_WORDS; i++) begin
			case (kind)
				0: begin re = (i % 2) ? 16'h8000 : 16'h7FFF; im = (i % 3) ? 16'h7FFF : 16'h8000; end
				1: begin re = 16'h7FFF; im = 16'h7FFF; end
				2: begin re = 16'h8000; im = 16'h8000; end
				3: begin
					re = 16'($signed(10'($urandom)));
					im = 16'($signed(10'($urandom)));
				end
				default: begin re = 16'($urandom); im = 16'($urandom); end
			endcase
			add_word(re, im, hold && i == 0, quiet);
		end
		add_word(step, 16'($urandom), 1'b0, quiet);
	endtask

	initial begin
		fail_count = 0;
		quiet_now = 0;
		in_ch.valid = 1'b0;
		in_ch.data = '0;
		out_ch.ready = 1'b0;
		arst_n = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// directed: extreme samples and extreme steps, then a quiet frame of random samples
		add_frame(0, 16'h0000, 0, 0);
		add_frame(1, 16'h7FFF, 0, 0);
		add_frame(2, 16'h8000, 1, 0);
		add_frame(4, 16'h4000, 0, 1);
		// random frames, mostly full-scale content
		for (int f = 0; f < 2; f++)
			add_frame($urandom_range(4, 3) == 3 && f == 1 ? 3 : 4, 16'($urandom),
				f == 1, 0);

		wait (tx_queue.size() == 0);
		@(posedge clk);
		while (in_ch.valid) @(posedge clk);
		while (bins_due.size() > 0) @(posedge clk);
		repeat (200) @(posedge clk);
		if (fail_count == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
